// File: sv/dtp_pkg.sv
package dtp_pkg;

   localparam logic [1:0] KIND_INTERVAL = 2'd0;
   localparam logic [1:0] KIND_TICK     = 2'd1;
   localparam logic [1:0] KIND_CHANNEL  = 2'd2;
   localparam logic [1:0] KIND_END      = 2'd3;

   localparam logic [2:0] ST_OK            = 3'd0;
   localparam logic [2:0] ST_SHORT         = 3'd1;
   localparam logic [2:0] ST_ZERO_INTERVAL = 3'd2;
   localparam logic [2:0] ST_ZERO_LENGTH   = 3'd3;
   localparam logic [2:0] ST_TRUNCATED     = 3'd4;
   localparam logic [2:0] ST_RECORD_SHORT  = 3'd5;

   localparam logic [7:0] NUM_KNOWN_IDS      = 8'd13;
   localparam logic [7:0] ID_TEMP_BYTE       = 8'h09;
   localparam logic [7:0] ID_TEMP_HUNDREDTHS = 8'h0B;
   localparam logic [2:0] MIN_PAYLOAD_BYTES  = 3'd7;

   typedef struct packed {
      logic [1:0]         kind;
      logic [4:0]         channel;
      logic signed [32:0] value;
      logic [2:0]         status;
      logic               last;
   } result_type;

   // Up to two result words are produced for one payload byte.
   typedef struct packed {
      logic [1:0]  count;
      result_type  first;
      result_type  second;
   } push_type;

   // Number of values carried by a known record id.
   function automatic logic [2:0] id_fields(input logic [3:0] id);
      case (id)
         4'h1:    id_fields = 3'd4;
         4'h4:    id_fields = 3'd2;
         4'h5:    id_fields = 3'd3;
         4'hA:    id_fields = 3'd3;
         default: id_fields = 3'd1;
      endcase
   endfunction

   // Bytes per value of a known record id.
   function automatic logic [2:0] id_width(input logic [3:0] id);
      case (id)
         4'h1, 4'h4, 4'h5, 4'h6, 4'hA: id_width = 3'd4;
         4'h2, 4'h7, 4'hB, 4'hC:       id_width = 3'd2;
         default:                      id_width = 3'd1;
      endcase
   endfunction

   // Data bytes a known record id needs in total.
   function automatic logic [4:0] id_need(input logic [3:0] id);
      case (id)
         4'h1:                   id_need = 5'd16;
         4'h4:                   id_need = 5'd8;
         4'h5, 4'hA:             id_need = 5'd12;
         4'h6:                   id_need = 5'd4;
         4'h2, 4'h7, 4'hB, 4'hC: id_need = 5'd2;
         default:                id_need = 5'd1;
      endcase
   endfunction

   // First channel code of a known record id.
   function automatic logic [4:0] id_base(input logic [3:0] id);
      case (id)
         4'h0:    id_base = 5'd0;
         4'h1:    id_base = 5'd1;
         4'h2:    id_base = 5'd5;
         4'h3:    id_base = 5'd6;
         4'h4:    id_base = 5'd7;
         4'h5:    id_base = 5'd9;
         4'h6:    id_base = 5'd12;
         4'h7:    id_base = 5'd13;
         4'h8:    id_base = 5'd14;
         4'h9:    id_base = 5'd15;
         4'hA:    id_base = 5'd16;
         4'hB:    id_base = 5'd19;
         4'hC:    id_base = 5'd20;
         default: id_base = 5'd0;
      endcase
   endfunction

endpackage

// File: sv/dtp_decoder.sv
module dtp_decoder
   import dtp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] payload_byte,
   input  logic       end_of_payload,
   output push_type   push
);

   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_LENGTH = 3'd1;
   localparam logic [2:0] PH_ID     = 3'd2;
   localparam logic [2:0] PH_DATA   = 3'd3;
   localparam logic [2:0] PH_SKIP   = 3'd4;

   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  header_count_ff, header_count_in;
   logic [7:0]  remaining_ff, remaining_in;
   logic [7:0]  record_id_ff, record_id_in;
   logic [1:0]  field_index_ff, field_index_in;
   logic [2:0]  taken_ff, taken_in;
   logic [31:0] acc_ff, acc_in;
   logic [2:0]  total_ff, total_in;
   logic [2:0]  error_ff, error_in;

   logic        emit_value;
   result_type  value_word;
   result_type  end_word;
   logic [3:0]  data_id;
   logic [2:0]  status;
   logic [7:0]  rem_dec;

   always_comb begin
      phase_in        = phase_ff;
      header_count_in = header_count_ff;
      remaining_in    = remaining_ff;
      record_id_in    = record_id_ff;
      field_index_in  = field_index_ff;
      taken_in        = taken_ff;
      acc_in          = acc_ff;
      error_in        = error_ff;
      total_in        = (total_ff < MIN_PAYLOAD_BYTES) ? total_ff + 3'd1 : total_ff;
      emit_value      = 1'b0;
      value_word      = '0;
      rem_dec         = remaining_ff - 8'd1;
      data_id         = (record_id_ff < NUM_KNOWN_IDS) ? record_id_ff[3:0] : 4'h0;

      unique case (phase_ff)
         PH_HEADER: begin
            acc_in          = {16'h0, acc_ff[7:0], payload_byte};
            header_count_in = header_count_ff + 2'd1;
            if (header_count_in == 2'd2) begin
               if (acc_in == 32'h0 && error_ff == ST_OK) begin
                  error_in = ST_ZERO_INTERVAL;
               end
               emit_value       = 1'b1;
               value_word.kind  = KIND_INTERVAL;
               value_word.value = {1'b0, acc_in};
               acc_in           = '0;
            end else if (header_count_in == 2'd0) begin
               emit_value       = 1'b1;
               value_word.kind  = KIND_TICK;
               value_word.value = {1'b0, acc_in};
               acc_in           = '0;
               phase_in         = PH_LENGTH;
            end
         end
         PH_LENGTH: begin
            if (payload_byte == 8'h0) begin
               if (error_ff == ST_OK) begin
                  error_in = ST_ZERO_LENGTH;
               end
            end else begin
               remaining_in = payload_byte;
               phase_in     = PH_ID;
            end
         end
         PH_ID: begin
            record_id_in = payload_byte;
            remaining_in = rem_dec;
            if (payload_byte < NUM_KNOWN_IDS) begin
               if (rem_dec < {3'b0, id_need(payload_byte[3:0])}) begin
                  if (error_ff == ST_OK) begin
                     error_in = ST_RECORD_SHORT;
                  end
                  phase_in = (rem_dec != 8'h0) ? PH_SKIP : PH_LENGTH;
               end else begin
                  field_index_in = '0;
                  taken_in       = '0;
                  acc_in         = '0;
                  phase_in       = PH_DATA;
               end
            end else begin
               phase_in = (rem_dec != 8'h0) ? PH_SKIP : PH_LENGTH;
            end
         end
         PH_DATA: begin
            acc_in       = {acc_ff[23:0], payload_byte};
            remaining_in = rem_dec;
            taken_in     = taken_ff + 3'd1;
            if (taken_in >= id_width(data_id)) begin
               emit_value         = 1'b1;
               value_word.kind    = KIND_CHANNEL;
               value_word.channel = id_base(data_id) + {3'b0, field_index_ff};
               if ({4'h0, data_id} == ID_TEMP_BYTE) begin
                  value_word.value = {{25{acc_in[7]}}, acc_in[7:0]};
               end else if ({4'h0, data_id} == ID_TEMP_HUNDREDTHS) begin
                  value_word.value = {{17{acc_in[15]}}, acc_in[15:0]};
               end else begin
                  value_word.value = {1'b0, acc_in};
               end
               acc_in         = '0;
               taken_in       = '0;
               field_index_in = field_index_ff + 2'd1;
               if (field_index_in == 2'd0 || {1'b0, field_index_in} >= id_fields(data_id)) begin
                  phase_in = (rem_dec != 8'h0) ? PH_SKIP : PH_LENGTH;
               end
            end
         end
         default: begin
            remaining_in = rem_dec;
            if (rem_dec == 8'h0) begin
               phase_in = PH_LENGTH;
            end
         end
      endcase

      // End status takes the state as it stands after this byte.
      if (total_in < MIN_PAYLOAD_BYTES) begin
         status = ST_SHORT;
      end else if (error_in != ST_OK) begin
         status = error_in;
      end else if (phase_in != PH_LENGTH) begin
         status = ST_TRUNCATED;
      end else begin
         status = ST_OK;
      end
      end_word        = '0;
      end_word.kind   = KIND_END;
      end_word.status = status;
      end_word.last   = 1'b1;

      push = '0;
      if (accept) begin
         if (emit_value && end_of_payload) begin
            push.count  = 2'd2;
            push.first  = value_word;
            push.second = end_word;
         end else if (emit_value) begin
            push.count      = 2'd1;
            push.first      = value_word;
            push.first.last = 1'b1;
         end else if (end_of_payload) begin
            push.count = 2'd1;
            push.first = end_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && end_of_payload)) begin
         phase_ff        <= PH_HEADER;
         header_count_ff <= '0;
         remaining_ff    <= '0;
         record_id_ff    <= '0;
         field_index_ff  <= '0;
         taken_ff        <= '0;
         acc_ff          <= '0;
         total_ff        <= '0;
         error_ff        <= ST_OK;
      end else if (accept) begin
         phase_ff        <= phase_in;
         header_count_ff <= header_count_in;
         remaining_ff    <= remaining_in;
         record_id_ff    <= record_id_in;
         field_index_ff  <= field_index_in;
         taken_ff        <= taken_in;
         acc_ff          <= acc_in;
         total_ff        <= total_in;
         error_ff        <= error_in;
      end
   end

endmodule

// File: sv/dtp_out_queue.sv
module dtp_out_queue
   import dtp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output result_type head,
   output logic       room
);

   result_type  entry_ff [4];
   logic [1:0]  rd_ptr_ff, rd_ptr_in;
   logic [1:0]  wr_ptr_ff, wr_ptr_in;
   logic [2:0]  count_ff, count_in;
   logic        pop;

   assign rsp_valid = (count_ff != 3'd0);
   assign head      = entry_ff[rd_ptr_ff];
   assign room      = (count_ff <= 3'd2);
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      wr_ptr_in = wr_ptr_ff + push.count;
      count_in  = count_ff + {1'b0, push.count} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + 2'd1] <= push.second;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4)
      else $error("output queue count exceeds its depth");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> room)
      else $error("words pushed without room for two");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && push.count == 2'd0) |=> (count_ff == $past(count_ff) - 3'd1))
      else $error("queue count did not drop after a word was taken");

endmodule

// File: sv/diagnostic_tlv_payload_parser_top.sv
// A result word is registered in the output queue when its payload byte is accepted.
// Payload bytes are taken one per cycle while req_stall is low; a byte that completes
//   a value and also ends the payload makes two words, the second behind the first.
// Input stall rises only while the four-word output queue has fewer than two free slots.
// Reset is synchronous and active high: it returns the parser to the first header byte
//   and empties the output queue. The parser also returns there after each final byte.
module diagnostic_tlv_payload_parser_top
   import dtp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_payload_byte,
   input  logic               req_end_of_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic [4:0]         rsp_channel,
   output logic signed [32:0] rsp_value,
   output logic [2:0]         rsp_status,
   output logic               rsp_last
);

   // The decoder holds the parse state and turns each accepted byte into zero, one
   // or two result words. The output queue decouples the two sides so that a byte
   // can be taken while earlier words still wait for the consumer.
   logic       accept;
   logic       room;
   push_type   push;
   result_type head;

   // Stall depends only on the registered queue fill, never on req_valid.
   assign req_stall = !room;
   assign accept    = req_valid && !req_stall;

   dtp_decoder u_decoder (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .payload_byte   (req_payload_byte),
      .end_of_payload (req_end_of_payload),
      .push           (push)
   );

   dtp_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .head      (head),
      .room      (room)
   );

   // The head word of the queue is the result port; it holds while stalled.
   assign rsp_kind    = head.kind;
   assign rsp_channel = head.channel;
   assign rsp_value   = head.value;
   assign rsp_status  = head.status;
   assign rsp_last    = head.last;

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the diagnostic payload parser. Payloads are sent one byte per
// input word. A predictor in this module decodes every accepted byte and queues the
// result words it should cause. A checker pops that queue as result words leave the block.
module tb
   import dtp_pkg::*;
();

   // A correct run ends well within this limit, so the limit only catches a hang.
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int WORDS_PER_PHASE = 475;
   localparam int HOLD_CYCLES     = 64;

   // Where the predictor is within one payload.
   typedef enum logic [2:0] {
      PARSE_HEADER,
      PARSE_LENGTH,
      PARSE_ID,
      PARSE_DATA,
      PARSE_SKIP
   } parse_phase_type;

   // Record layout, indexed by known id 0x00 to 0x0C.
   localparam logic [0:12][2:0] VALUES_PER_ID = {
      3'd1, 3'd4, 3'd1, 3'd1, 3'd2, 3'd3, 3'd1, 3'd1, 3'd1, 3'd1, 3'd3, 3'd1, 3'd1};
   localparam logic [0:12][2:0] BYTES_PER_VALUE = {
      3'd1, 3'd4, 3'd2, 3'd1, 3'd4, 3'd4, 3'd4, 3'd2, 3'd1, 3'd1, 3'd4, 3'd2, 3'd2};
   localparam logic [0:12][4:0] FIRST_CHANNEL = {
      5'd0, 5'd1, 5'd5, 5'd6, 5'd7, 5'd9, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd19, 5'd20};

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_payload_byte = 8'd0;
   logic               req_end_of_payload = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_kind;
   logic [4:0]         rsp_channel;
   logic signed [32:0] rsp_value;
   logic [2:0]         rsp_status;
   logic               rsp_last;

   // Predictor state for the payload in progress.
   parse_phase_type cur_phase;
   logic [1:0]   hdr_count;
   logic [7:0]   rec_left;
   logic [7:0]   rec_id;
   logic [1:0]   fld_index;
   logic [2:0]   fld_bytes;
   logic [31:0]  acc;
   logic [2:0]   byte_count;
   logic [2:0]   first_error;

   result_type   pending_words [$];
   logic [7:0]   payload_bytes [$];

   int  error_count = 0;
   int  cycle_count = 0;
   int  words_sent = 0;
   int  send_idle_pct = 0;
   int  stall_pct = 0;
   logic holding = 1'b0;
   event hold_off_go;

   diagnostic_tlv_payload_parser_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_payload_byte   (req_payload_byte),
      .req_end_of_payload (req_end_of_payload),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_channel        (rsp_channel),
      .rsp_value          (rsp_value),
      .rsp_status         (rsp_status),
      .rsp_last           (rsp_last)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // The run is ended here if the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Predictor.
   // ---------------------------------------------------------------------------------------

   // The parser goes back to this state after reset and after every final byte.
   function automatic void clear_parser();
      cur_phase   = PARSE_HEADER;
      hdr_count   = 2'd0;
      rec_left    = 8'd0;
      rec_id      = 8'd0;
      fld_index   = 2'd0;
      fld_bytes   = 3'd0;
      acc         = 32'd0;
      byte_count  = 3'd0;
      first_error = ST_OK;
   endfunction

   // Only the first of the recorded errors is kept for the end status.
   function automatic void note_fault(logic [2:0] code);
      if (first_error == ST_OK) begin
         first_error = code;
      end
   endfunction

   // Leftover data bytes of a record are skipped; otherwise a new length byte follows.
   function automatic void finish_record_data();
      cur_phase = (rec_left != 8'd0) ? PARSE_SKIP : PARSE_LENGTH;
   endfunction

   function automatic result_type result_word(logic [1:0] kind, logic [4:0] chan,
                                              logic [32:0] val, logic [2:0] code);
      result_type w;
      w.kind    = kind;
      w.channel = chan;
      w.value   = val;
      w.status  = code;
      w.last    = 1'b0;
      return w;
   endfunction

   // Decodes one accepted payload byte and queues the result words it causes.
   function automatic void decode_payload_byte(logic [7:0] b, logic eop);
      int          words_before;
      logic [3:0]  idx;
      logic [4:0]  need;
      logic [32:0] val;
      logic [2:0]  code;
      result_type  tail;
      words_before = pending_words.size();
      if (byte_count < MIN_PAYLOAD_BYTES) begin
         byte_count = byte_count + 3'd1;
      end
      case (cur_phase)
         PARSE_HEADER: begin
            // The interval and the tick are 16 bits each, high byte first.
            acc = {16'd0, acc[7:0], b};
            hdr_count = hdr_count + 2'd1;
            if (hdr_count == 2'd2) begin
               if (acc == 32'd0) begin
                  note_fault(ST_ZERO_INTERVAL);
               end
               pending_words.push_back(result_word(KIND_INTERVAL, 5'd0, {17'd0, acc[15:0]},
                                                   ST_OK));
               acc = 32'd0;
            end else if (hdr_count == 2'd0) begin
               pending_words.push_back(result_word(KIND_TICK, 5'd0, {17'd0, acc[15:0]},
                                                   ST_OK));
               acc = 32'd0;
               cur_phase = PARSE_LENGTH;
            end
         end
         PARSE_LENGTH: begin
            // A zero length is an empty record: the next byte is a length again.
            if (b == 8'd0) begin
               note_fault(ST_ZERO_LENGTH);
            end else begin
               rec_left  = b;
               cur_phase = PARSE_ID;
            end
         end
         PARSE_ID: begin
            rec_id   = b;
            rec_left = rec_left - 8'd1;
            if (b < NUM_KNOWN_IDS) begin
               idx  = b[3:0];
               need = {2'd0, VALUES_PER_ID[idx]} * {2'd0, BYTES_PER_VALUE[idx]};
               if (rec_left < {3'd0, need}) begin
                  note_fault(ST_RECORD_SHORT);
                  finish_record_data();
               end else begin
                  fld_index = 2'd0;
                  fld_bytes = 3'd0;
                  acc       = 32'd0;
                  cur_phase = PARSE_DATA;
               end
            end else begin
               finish_record_data();
            end
         end
         PARSE_DATA: begin
            idx       = rec_id[3:0];
            acc       = {acc[23:0], b};
            rec_left  = rec_left - 8'd1;
            fld_bytes = fld_bytes + 3'd1;
            if (fld_bytes >= BYTES_PER_VALUE[idx]) begin
               // Only the two temperature channels carry a sign.
               val = {1'b0, acc};
               if (rec_id == ID_TEMP_BYTE && acc[7]) begin
                  val = {{25{1'b1}}, acc[7:0]};
               end else if (rec_id == ID_TEMP_HUNDREDTHS && acc[15]) begin
                  val = {{17{1'b1}}, acc[15:0]};
               end
               pending_words.push_back(result_word(KIND_CHANNEL,
                                                   FIRST_CHANNEL[idx] + {3'd0, fld_index},
                                                   val, ST_OK));
               acc       = 32'd0;
               fld_bytes = 3'd0;
               fld_index = fld_index + 2'd1;
               if (fld_index == 2'd0 || fld_index >= VALUES_PER_ID[idx]) begin
                  finish_record_data();
               end
            end
         end
         default: begin
            rec_left = rec_left - 8'd1;
            if (rec_left == 8'd0) begin
               cur_phase = PARSE_LENGTH;
            end
         end
      endcase
      if (eop) begin
         // A short payload overrides everything; a recorded error overrides truncation.
         if (byte_count < MIN_PAYLOAD_BYTES) begin
            code = ST_SHORT;
         end else if (first_error != ST_OK) begin
            code = first_error;
         end else if (cur_phase != PARSE_LENGTH) begin
            code = ST_TRUNCATED;
         end else begin
            code = ST_OK;
         end
         pending_words.push_back(result_word(KIND_END, 5'd0, 33'd0, code));
         clear_parser();
      end
      if (pending_words.size() > words_before) begin
         tail = pending_words.pop_back();
         tail.last = 1'b1;
         pending_words.push_back(tail);
      end
   endfunction

   // ---------------------------------------------------------------------------------------
   // Result side: random stalls, the long hold-off, and the checker.
   // ---------------------------------------------------------------------------------------

   always @(posedge clock) begin
      rsp_stall <= holding || ($urandom_range(99) < stall_pct);
   end

   // The long hold-off counts its own cycles so that the sender keeps going meanwhile.
   initial begin
      forever begin
         @(hold_off_go);
         holding <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         holding <= 1'b0;
      end
   end

   task automatic report_field(input string name, input logic [32:0] want,
                               input logic [32:0] got);
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      error_count++;
   endtask

   // Every result word taken from the block is held against the oldest prediction.
   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_words.size() == 0) begin
            $display({"%0t: unexpected word, expected none, got kind %0d channel %0d",
                      " value %h status %0d last %0d"},
                     $time, rsp_kind, rsp_channel, rsp_value, rsp_status, rsp_last);
            error_count++;
         end else begin
            want = pending_words.pop_front();
            if (rsp_kind !== want.kind)       report_field("kind", want.kind, rsp_kind);
            if (rsp_channel !== want.channel) report_field("channel", want.channel, rsp_channel);
            if (rsp_value !== want.value)     report_field("value", want.value, rsp_value);
            if (rsp_status !== want.status)   report_field("status", want.status, rsp_status);
            if (rsp_last !== want.last)       report_field("last", want.last, rsp_last);
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Input side.
   // ---------------------------------------------------------------------------------------

   // Offers one word, idling first at the current rate, and holds it until it is taken.
   // The prediction is made at the edge that accepts the word.
   task automatic send_word(input logic [7:0] b, input logic eop);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_payload_byte   <= b;
      req_end_of_payload <= eop;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_payload_byte(b, eop);
      words_sent++;
   endtask

   // Sends the assembled payload with the end flag on its last byte.
   task automatic send_payload();
      foreach (payload_bytes[i]) begin
         send_word(payload_bytes[i], i == payload_bytes.size() - 1);
      end
   endtask

   // Data bytes lean toward the extremes so that sign and carry edges come up often.
   function automatic logic [7:0] pick_data_byte();
      case ($urandom_range(9))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h80;
         3:       return 8'h7F;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Appends a record: its length byte, its id, and data_len data bytes.
   task automatic add_record(input logic [7:0] id, input int data_len);
      payload_bytes.push_back(8'(data_len + 1));
      payload_bytes.push_back(id);
      repeat (data_len) payload_bytes.push_back(pick_data_byte());
   endtask

   // Most payloads are well formed with random content; the rest carry zero lengths,
   // records that are too short, unknown ids, early ends or plain noise.
   task automatic make_random_payload();
      int         roll;
      int         need;
      int         cut;
      logic [7:0] id;
      payload_bytes = {};
      if ($urandom_range(99) < 8) begin
         repeat ($urandom_range(24, 1)) payload_bytes.push_back(8'($urandom_range(255)));
         return;
      end
      if ($urandom_range(99) < 5) begin
         payload_bytes.push_back(8'h00);
         payload_bytes.push_back(8'h00);
      end else begin
         payload_bytes.push_back(pick_data_byte());
         payload_bytes.push_back(pick_data_byte());
      end
      payload_bytes.push_back(pick_data_byte());
      payload_bytes.push_back(pick_data_byte());
      repeat ($urandom_range(5)) begin
         roll = $urandom_range(99);
         id   = 8'($urandom_range(12));
         need = int'(VALUES_PER_ID[id[3:0]]) * int'(BYTES_PER_VALUE[id[3:0]]);
         if (roll < 5) begin
            payload_bytes.push_back(8'h00);
         end else if (roll < 12) begin
            // Unknown ids, now and then with the longest record the length byte allows.
            id = 8'($urandom_range(255, 13));
            add_record(id, ($urandom_range(40) == 0) ? 254 : $urandom_range(6));
         end else if (roll < 20) begin
            add_record(id, $urandom_range(need - 1));
         end else begin
            add_record(id, need + (($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0));
         end
      end
      roll = $urandom_range(99);
      if (roll < 10 && payload_bytes.size() > 1) begin
         // The payload ends inside a record.
         cut = $urandom_range((payload_bytes.size() > 6) ? 5 : payload_bytes.size() - 1, 1);
         repeat (cut) void'(payload_bytes.pop_back());
      end else if (roll < 15) begin
         // The payload ends before its minimum length.
         while (payload_bytes.size() > 6) void'(payload_bytes.pop_back());
         cut = $urandom_range(payload_bytes.size() - 1);
         repeat (cut) void'(payload_bytes.pop_back());
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------------------------

   // Hand-made payloads for the status codes, the signed channels and early ends.
   task automatic test_directed_cases();
      send_idle_pct = 0;
      stall_pct     = 0;
      // A zero interval followed by a zero-length record: the first error wins.
      // The temperature in hundredths is the most negative value.
      payload_bytes = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h03, 8'h0B, 8'h80, 8'h00};
      send_payload();
      // A record of id 0x05 with one data byte is too short; its byte is skipped.
      payload_bytes = '{8'h01, 8'h00, 8'h00, 8'h01, 8'h02, 8'h05, 8'hFF};
      send_payload();
      // A negative one-byte temperature, then the payload ends right after an id.
      payload_bytes = '{8'h00, 8'h01, 8'h00, 8'h02, 8'h02, 8'h09, 8'h80, 8'h03, 8'h0C};
      send_payload();
      // The end flag on the second byte makes the interval and the end status together.
      payload_bytes = '{8'hFF, 8'hFF};
      send_payload();
      // A payload of a single byte.
      payload_bytes = '{8'h5A};
      send_payload();
   endtask

   // The receiver holds off for a long stretch while full-length records stream in, so the
   // output queue fills and the block must stall its input.
   task automatic test_back_pressure();
      send_idle_pct = 0;
      stall_pct     = 0;
      -> hold_off_go;
      payload_bytes = '{8'h12, 8'h34, 8'h56, 8'h78};
      add_record(8'h01, 16);
      add_record(8'h05, 12);
      add_record(8'h0A, 12);
      send_payload();
   endtask

   // Random payloads at one setting of sender idling and receiver stalls.
   task automatic test_random_traffic(input int idle_pct, input int stall_rate);
      int goal;
      send_idle_pct = idle_pct;
      stall_pct     = stall_rate;
      goal          = words_sent + WORDS_PER_PHASE;
      while (words_sent < goal) begin
         make_random_payload();
         send_payload();
      end
   endtask

   initial begin
      clear_parser();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_back_pressure();
      test_random_traffic(0, 0);
      test_random_traffic(82, 0);
      test_random_traffic(0, 82);
      test_random_traffic(25, 25);
      req_valid <= 1'b0;
      // Drain the outstanding words, then keep watching so that any extra word would show.
      while (pending_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/dtp_pkg.sv
sv/dtp_decoder.sv
sv/dtp_out_queue.sv
sv/diagnostic_tlv_payload_parser_top.sv
test/tb.sv
